>>> design/eye_pupil_compositor_unit_macros.svh
// ----------------------------------------------------------------------------
// Eye pupil compositor assertion macros
// Shared concurrent assertion forms, clocked on clk, quiet during reset.
// ----------------------------------------------------------------------------
`ifndef EYE_PUPIL_COMPOSITOR_UNIT_MACROS_SVH
`define EYE_PUPIL_COMPOSITOR_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define EPC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold after the antecedent, at the render result latency
`define EPC_ASSERT_LAT2(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> ##1 (cons)) \
    else $error(msg);

`endif

>>> design/epc_pkg.sv
// ----------------------------------------------------------------------------
// Eye pupil compositor package
// Request codes, register indexes, reset values and default matrix size.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package epc_pkg;

  // Default eye matrix size
  localparam int EPC_EYE_W_DEF = 16;
  localparam int EPC_EYE_H_DEF = 8;

  // Request codes
  localparam logic [1:0] REQ_FRAME  = 2'd0;
  localparam logic [1:0] REQ_PUPIL  = 2'd1;
  localparam logic [1:0] REQ_RENDER = 2'd2;

  // Configuration register indexes
  localparam logic CFG_CENTER_X = 1'b0;
  localparam logic CFG_CENTER_Y = 1'b1;

  localparam int CFG_DW = 4;

  // Register reset values
  localparam logic [3:0] CENTER_X_RST = 4'd8;
  localparam logic [2:0] CENTER_Y_RST = 3'd4;

endpackage

`default_nettype wire

>>> design/eye_pupil_compositor_unit.sv
// ----------------------------------------------------------------------------
// Eye pupil compositor unit
// Stores frame and pupil bitmaps and renders one left/right eye pixel pair.
// ----------------------------------------------------------------------------
// One request is taken every clock; busy is always low. Load requests write
// the frame or pupil bitmap and give no result. A render request gives its
// pixel pair on out_left_pixel/out_right_pixel with out_valid high for one
// cycle, once it has passed the read stage, which reads both bitmaps through
// their two read ports, and the output register, which holds the composed
// pixels. The receiver cannot stall results, so it must take
// every out_valid cycle. Bitmaps have no reset and no clearing pass: render
// only pixels whose entries were loaded. Write the pupil centre registers
// only while no render request is in flight.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module eye_pupil_compositor_unit
  import epc_pkg::*;
#(
  parameter int EYE_W = EPC_EYE_W_DEF,
  parameter int EYE_H = EPC_EYE_H_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  // Configuration
  input  wire logic              cfg_we,
  input  wire logic              cfg_index,
  input  wire logic [CFG_DW-1:0] cfg_wdata,
  // Request
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [1:0]        in_req_type,
  input  wire logic [3:0]        in_pixel_x,
  input  wire logic [2:0]        in_pixel_y,
  input  wire logic signed [4:0] in_gaze_x,
  input  wire logic signed [3:0] in_gaze_y,
  input  wire logic [1:0]        in_write_value,
  // Result
  output logic                   out_valid,
  output logic [1:0]             out_left_pixel,
  output logic [1:0]             out_right_pixel
);

  localparam int CELLS = EYE_W * EYE_H;
  localparam int AW    = $clog2(CELLS);
  localparam int SW    = $clog2(EYE_W / 2 + EYE_H / 2 + 64) + 2;

  localparam logic signed [SW-1:0] W_S    = SW'(EYE_W);
  localparam logic signed [SW-1:0] H_S    = SW'(EYE_H);
  localparam logic signed [SW-1:0] HALF_W = SW'(EYE_W / 2);
  localparam logic signed [SW-1:0] HALF_H = SW'(EYE_H / 2);
  localparam logic signed [SW-1:0] ONE_S  = SW'(1);
  localparam logic [AW-1:0]        W_A    = AW'(EYE_W);
  localparam logic [AW-1:0]        WM1_A  = AW'(EYE_W - 1);

  // Configuration registers
  logic [3:0] center_x_r;
  logic [2:0] center_y_r;

  // Request decode and position math
  logic                 accept;
  logic                 on_matrix;
  logic                 render;
  logic signed [SW-1:0] x_s, y_s, gx_s, gy_s, cx_s, cy_s;
  logic signed [SW-1:0] dx_s, exl_s, exr_s, ey_s;
  logic                 ey_in, pl_in, pr_in;
  logic [AW-1:0]        fl_addr, fr_addr, pl_addr, pr_addr;

  // Memory read data
  logic [1:0] fl_rd, fr_rd;
  logic [0:0] pl_rd, pr_rd;

  // Read stage and output stage
  logic       s1_vld_r, s1_vld_nxt;
  logic       s1_inside_r;
  logic       s1_pl_hit_r;
  logic       s1_pr_hit_r;
  logic       out_valid_r;
  logic [1:0] out_left_r, out_left_nxt;
  logic [1:0] out_right_r, out_right_nxt;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r <= CENTER_X_RST;
      center_y_r <= CENTER_Y_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CENTER_X: center_x_r <= cfg_wdata[3:0];
        CFG_CENTER_Y: center_y_r <= cfg_wdata[2:0];
        default: ;
      endcase
    end
  end

  // Widen the request fields to one signed width
  assign x_s  = $signed({{(SW-4){1'b0}}, in_pixel_x});
  assign y_s  = $signed({{(SW-3){1'b0}}, in_pixel_y});
  assign gx_s = $signed({{(SW-5){in_gaze_x[4]}}, in_gaze_x});
  assign gy_s = $signed({{(SW-4){in_gaze_y[3]}}, in_gaze_y});
  assign cx_s = $signed({{(SW-4){1'b0}}, center_x_r});
  assign cy_s = $signed({{(SW-3){1'b0}}, center_y_r});

  assign on_matrix = (x_s < W_S) && (y_s < H_S);
  assign render    = accept && (in_req_type == REQ_RENDER) && on_matrix;

  // Shift the pupil by gaze and centre, mirror it for the right eye
  assign dx_s  = x_s - gx_s - HALF_W;
  assign exl_s = dx_s + cx_s;
  assign exr_s = cx_s - dx_s - ONE_S;
  assign ey_s  = y_s - gy_s - HALF_H + cy_s;

  assign ey_in = !ey_s[SW-1] && (ey_s < H_S);
  assign pl_in = ey_in && !exl_s[SW-1] && (exl_s < W_S);
  assign pr_in = ey_in && !exr_s[SW-1] && (exr_s < W_S);

  // Row-major bitmap addresses
  assign fl_addr = AW'(in_pixel_y) * W_A + AW'(in_pixel_x);
  assign fr_addr = AW'(in_pixel_y) * W_A + (WM1_A - AW'(in_pixel_x));
  assign pl_addr = AW'($unsigned(ey_s)) * W_A + AW'($unsigned(exl_s));
  assign pr_addr = AW'($unsigned(ey_s)) * W_A + AW'($unsigned(exr_s));

  // Frame bitmap: left and mirrored right columns
  epc_bitmap_ram #(
    .DW    (2),
    .DEPTH (CELLS),
    .AW    (AW)
  ) u_frame_ram (
    .clk     (clk),
    .we      (accept && (in_req_type == REQ_FRAME) && on_matrix),
    .waddr   (fl_addr),
    .wdata   (in_write_value),
    .re_a    (render),
    .raddr_a (fl_addr),
    .rdata_a (fl_rd),
    .re_b    (render),
    .raddr_b (fr_addr),
    .rdata_b (fr_rd)
  );

  // Pupil bitmap: read only where the shifted position is on the matrix
  epc_bitmap_ram #(
    .DW    (1),
    .DEPTH (CELLS),
    .AW    (AW)
  ) u_pupil_ram (
    .clk     (clk),
    .we      (accept && (in_req_type == REQ_PUPIL) && on_matrix),
    .waddr   (fl_addr),
    .wdata   (in_write_value[0]),
    .re_a    (render && pl_in),
    .raddr_a (pl_addr),
    .rdata_a (pl_rd),
    .re_b    (render && pr_in),
    .raddr_b (pr_addr),
    .rdata_b (pr_rd)
  );

  // Track the request through the read stage
  assign s1_vld_nxt = accept && (in_req_type == REQ_RENDER);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= s1_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_inside_r <= on_matrix;
    s1_pl_hit_r <= pl_in;
    s1_pr_hit_r <= pr_in;
  end

  // Compose: frame bit 0, or frame bit 1 gated by the pupil hit; dark off the matrix
  always_comb begin
    out_left_nxt  = 2'b00;
    out_right_nxt = 2'b00;
    if (s1_inside_r) begin
      out_left_nxt  = {fl_rd[1] & s1_pl_hit_r & pl_rd[0], fl_rd[0]};
      out_right_nxt = {fr_rd[1] & s1_pr_hit_r & pr_rd[0], fr_rd[0]};
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_vld_r) begin
      out_left_r  <= out_left_nxt;
      out_right_r <= out_right_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_left_pixel  = out_left_r;
  assign out_right_pixel = out_right_r;

  // Checks
  `include "eye_pupil_compositor_unit_macros.svh"

  `EPC_ASSERT_LAT2(a_render_gives_result, accept && (in_req_type == REQ_RENDER), out_valid, "render request lost")
  `EPC_ASSERT_LAT2(a_load_gives_none, accept && (in_req_type != REQ_RENDER), !out_valid, "result from a non-render request")
  `EPC_ASSERT_LAT2(a_outside_dark, accept && (in_req_type == REQ_RENDER) && !on_matrix, (out_left_pixel == 2'b00) && (out_right_pixel == 2'b00), "pixel off the matrix lit")

endmodule

`default_nettype wire

>>> design/epc_bitmap_ram.sv
// ----------------------------------------------------------------------------
// Eye pupil compositor bitmap memory
// One write port and two registered read ports with read enables.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module epc_bitmap_ram #(
  parameter int DW    = 2,
  parameter int DEPTH = 128,
  parameter int AW    = 7
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic          re_a,
  input  wire logic [AW-1:0] raddr_a,
  output logic      [DW-1:0] rdata_a,
  input  wire logic          re_b,
  input  wire logic [AW-1:0] raddr_b,
  output logic      [DW-1:0] rdata_b
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_a_r;
  logic [DW-1:0] rdata_b_r;

  // Write one entry
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read two entries, hold data when not enabled
  always_ff @(posedge clk) begin
    if (re_a) begin
      rdata_a_r <= mem[raddr_a];
    end
    if (re_b) begin
      rdata_b_r <= mem[raddr_b];
    end
  end

  assign rdata_a = rdata_a_r;
  assign rdata_b = rdata_b_r;

endmodule

`default_nettype wire

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// Eye pupil compositor testbench
// Loads both bitmaps, then runs directed and random requests under several
// pupil centre settings. Each rendered pixel pair is checked against a local
// prediction of the frame/pupil blend, in request order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import epc_pkg::*;

  localparam int COLS = EPC_EYE_W_DEF;
  localparam int ROWS = EPC_EYE_H_DEF;
  localparam int CELLS = COLS * ROWS;
  // Request code with no meaning; the block must drop it
  localparam logic [1:0] REQ_NONE = 2'd3;
  // Margin past the render latency before idle writes
  localparam int SETTLE = 4;
  localparam int RANDOM_ITEMS = 880;

  typedef struct packed {
    logic [1:0] left_px;
    logic [1:0] right_px;
  } pixel_pair_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_we = 1'b0;
  logic              cfg_index = CFG_CENTER_X;
  logic [CFG_DW-1:0] cfg_wdata = '0;
  logic              start = 1'b0;
  logic              busy;
  logic [1:0]        in_req_type = REQ_FRAME;
  logic [3:0]        in_pixel_x = '0;
  logic [2:0]        in_pixel_y = '0;
  logic signed [4:0] in_gaze_x = '0;
  logic signed [3:0] in_gaze_y = '0;
  logic [1:0]        in_write_value = '0;
  logic              out_valid;
  logic [1:0]        out_left_pixel;
  logic [1:0]        out_right_pixel;

  // Local copy of the block state
  logic [1:0] frame_mem [CELLS];
  logic       pupil_mem [CELLS];
  logic [3:0] center_x = CENTER_X_RST;
  logic [2:0] center_y = CENTER_Y_RST;

  pixel_pair_t pending_pixels [$];
  int          mismatch_count = 0;
  int          burst_left = 1;
  bit          req_up = 1'b0;

  eye_pupil_compositor_unit dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .start           (start),
    .busy            (busy),
    .in_req_type     (in_req_type),
    .in_pixel_x      (in_pixel_x),
    .in_pixel_y      (in_pixel_y),
    .in_gaze_x       (in_gaze_x),
    .in_gaze_y       (in_gaze_y),
    .in_write_value  (in_write_value),
    .out_valid       (out_valid),
    .out_left_pixel  (out_left_pixel),
    .out_right_pixel (out_right_pixel)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Pupil mark at bit 1, or nothing when the shifted spot is off the matrix
  function automatic logic [1:0] pupil_hit(int col, int row);
    if (col < 0 || col >= COLS || row < 0 || row >= ROWS) return 2'b00;
    return pupil_mem[row * COLS + col] ? 2'b10 : 2'b00;
  endfunction

  function automatic logic [1:0] blend(logic [1:0] frame, logic [1:0] hit);
    return (frame & 2'b01) | (frame & hit);
  endfunction

  // Compose the left pixel and its mirrored right partner
  function automatic pixel_pair_t render_pixel(logic [3:0] x, logic [2:0] y,
                                                logic signed [4:0] gx,
                                                logic signed [3:0] gy);
    int          dx;
    int          row;
    int          cx;
    pixel_pair_t pair;
    cx  = int'(center_x);
    dx  = int'(x) - int'(gx) - COLS / 2;
    row = int'(y) - int'(gy) - ROWS / 2 + int'(center_y);
    pair.left_px  = blend(frame_mem[int'(y) * COLS + int'(x)], pupil_hit(dx + cx, row));
    pair.right_px = blend(frame_mem[int'(y) * COLS + (COLS - 1 - int'(x))],
                          pupil_hit(cx - dx - 1, row));
    return pair;
  endfunction

  // Apply one accepted request to the local state; queue the pixel pair
  // (field widths keep every position inside the matrix)
  task automatic apply_request(logic [1:0] kind, logic [3:0] x, logic [2:0] y,
                               logic signed [4:0] gx, logic signed [3:0] gy,
                               logic [1:0] wv);
    int idx;
    idx = int'(y) * COLS + int'(x);
    case (kind)
      REQ_FRAME: begin
        frame_mem[idx] = wv;
      end
      REQ_PUPIL: begin
        pupil_mem[idx] = wv[0];
      end
      REQ_RENDER: begin
        pending_pixels.push_back(render_pixel(x, y, gx, gy));
      end
      default: begin
      end
    endcase
  endtask

  // Count down the current burst; drop start for a random gap at its end
  task automatic pace();
    burst_left--;
    if (burst_left <= 0) begin
      start <= 1'b0;
      req_up = 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                : $urandom_range(1, 12);
    end
  endtask

  // Present one request and hold it until taken
  task automatic send_req(logic [1:0] kind, logic [3:0] x, logic [2:0] y,
                          logic signed [4:0] gx, logic signed [3:0] gy,
                          logic [1:0] wv);
    start          <= 1'b1;
    req_up         = 1'b1;
    in_req_type    <= kind;
    in_pixel_x     <= x;
    in_pixel_y     <= y;
    in_gaze_x      <= gx;
    in_gaze_y      <= gy;
    in_write_value <= wv;
    do @(posedge clk); while (busy);
    apply_request(kind, x, y, gx, gy, wv);
    pace();
  endtask

  // Random request: mostly renders, small gaze half the time
  task automatic send_random(output bit counted);
    int                sel;
    logic [1:0]        kind;
    logic signed [4:0] gx;
    logic signed [3:0] gy;
    sel  = $urandom_range(0, 99);
    kind = (sel < 60) ? REQ_RENDER : (sel < 75) ? REQ_FRAME :
           (sel < 90) ? REQ_PUPIL : REQ_NONE;
    if ($urandom_range(0, 1)) begin
      gx = 5'($urandom_range(0, 31));
      gy = 4'($urandom_range(0, 15));
    end else begin
      gx = 5'(28 + $urandom_range(0, 8));
      gy = 4'(14 + $urandom_range(0, 4));
    end
    send_req(kind, 4'($urandom_range(0, 15)), 3'($urandom_range(0, 7)), gx, gy,
             2'($urandom_range(0, 3)));
    counted = (kind != REQ_NONE);
  endtask

  // Drop start, wait for every render to come back, then let the pipe empty
  task automatic drain();
    if (req_up) begin
      start <= 1'b0;
      req_up = 1'b0;
    end
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Write one register, then idle the port
  task automatic write_reg(logic index, logic [CFG_DW-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (index == CFG_CENTER_X) center_x = data;
    else center_y = data[2:0];
    @(posedge clk);
  endtask

  // Fill every frame and pupil entry so later renders read only loaded cells
  task automatic test_load_bitmaps();
    for (int i = 0; i < CELLS; i++) begin
      send_req(REQ_FRAME, 4'(i % COLS), 3'(i / COLS), 5'($urandom_range(0, 31)),
               4'($urandom_range(0, 15)), 2'($urandom_range(0, 3)));
    end
    for (int i = 0; i < CELLS; i++) begin
      send_req(REQ_PUPIL, 4'(i % COLS), 3'(i / COLS), 5'($urandom_range(0, 31)),
               4'($urandom_range(0, 15)), 2'($urandom_range(0, 3)));
    end
    drain();
  endtask

  // Corners, gaze extremes, pupil mark bit, dropped request code
  task automatic test_directed();
    send_req(REQ_RENDER, 4'd0, 3'd0, -5'sd16, -4'sd8, 2'd0);
    send_req(REQ_RENDER, 4'd15, 3'd7, 5'sd15, 4'sd7, 2'd3);
    send_req(REQ_RENDER, 4'd0, 3'd7, 5'sd0, 4'sd0, 2'd0);
    send_req(REQ_RENDER, 4'd15, 3'd0, -5'sd16, 4'sd7, 2'd0);
    send_req(REQ_RENDER, 4'd15, 3'd7, -5'sd16, -4'sd8, 2'd0);
    send_req(REQ_RENDER, 4'd0, 3'd0, 5'sd15, 4'sd7, 2'd0);
    // Centered gaze lands the pupil on the rendered cell itself
    send_req(REQ_FRAME, 4'd3, 3'd2, 5'sd0, 4'sd0, 2'd3);
    send_req(REQ_FRAME, 4'd12, 3'd2, 5'sd0, 4'sd0, 2'd2);
    send_req(REQ_PUPIL, 4'd3, 3'd2, 5'sd0, 4'sd0, 2'd2);
    send_req(REQ_PUPIL, 4'd12, 3'd2, 5'sd0, 4'sd0, 2'd1);
    send_req(REQ_RENDER, 4'd3, 3'd2, 5'sd0, 4'sd0, 2'd0);
    send_req(REQ_PUPIL, 4'd3, 3'd2, 5'sd0, 4'sd0, 2'd1);
    send_req(REQ_RENDER, 4'd3, 3'd2, 5'sd0, 4'sd0, 2'd0);
    send_req(REQ_RENDER, 4'd12, 3'd2, 5'sd0, 4'sd0, 2'd0);
    // Dropped requests must leave the bitmaps alone and give no pixel
    send_req(REQ_NONE, 4'd3, 3'd2, 5'sd0, 4'sd0, 2'd0);
    send_req(REQ_NONE, 4'd15, 3'd7, -5'sd1, -4'sd1, 2'd3);
    send_req(REQ_NONE, 4'd0, 3'd0, 5'sd0, 4'sd0, 2'd0);
    send_req(REQ_RENDER, 4'd3, 3'd2, 5'sd0, 4'sd0, 2'd0);
    send_req(REQ_RENDER, 4'd15, 3'd7, -5'sd1, -4'sd1, 2'd0);
    drain();
  endtask

  // Random traffic under a sweep of pupil centres, extremes included
  task automatic test_center_sweep();
    logic [CFG_DW-1:0] cx_list [8];
    logic [CFG_DW-1:0] cy_list [8];
    int                done;
    int                quota;
    bit                counted;
    cx_list = '{4'd0, 4'd15, 4'd0, 4'd15, 4'd8, 4'd7, 4'($urandom_range(0, 15)), 4'd8};
    cy_list = '{4'd0, 4'd7, 4'd7, 4'd0, 4'd15, 4'd9, 4'($urandom_range(0, 15)), 4'd4};
    quota = RANDOM_ITEMS / 8;
    for (int s = 0; s < 8; s++) begin
      drain();
      write_reg(CFG_CENTER_X, cx_list[s]);
      write_reg(CFG_CENTER_Y, cy_list[s]);
      done = 0;
      while (done < quota) begin
        send_random(counted);
        if (counted) done++;
      end
    end
    drain();
  endtask

  // Compare each pixel pair with the oldest prediction
  always @(posedge clk) begin
    pixel_pair_t want;
    if (rst_n && out_valid) begin
      if (pending_pixels.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected pixel pair left %0d right %0d", $time,
                 out_left_pixel, out_right_pixel);
      end else begin
        want = pending_pixels.pop_front();
        if (out_left_pixel !== want.left_px) begin
          mismatch_count++;
          $display("%0t: left pixel expected %0d got %0d", $time,
                   want.left_px, out_left_pixel);
        end
        if (out_right_pixel !== want.right_px) begin
          mismatch_count++;
          $display("%0t: right pixel expected %0d got %0d", $time,
                   want.right_px, out_right_pixel);
        end
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_load_bitmaps();
    test_directed();
    test_center_sweep();
    drain();
    if (pending_pixels.size() != 0) begin
      mismatch_count++;
      $display("%0t: %0d pixel pairs never arrived", $time, pending_pixels.size());
    end
    if (mismatch_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  // Hang guard
  initial begin
    #3ms;
    $display("testbench failed");
    $finish;
  end

endmodule
